// File: hdl/idab_pkg.sv
// ----------------------------------------------------------------------------
// ID allocator bidirectional map package
// Shared types, codes and sizes for the entity <-> network ID link table.
// ----------------------------------------------------------------------------
package idab_pkg;

  localparam int ID_COUNT   = 256;
  localparam int ID_W       = 8;
  localparam int ENT_W      = 8;
  localparam int ENT_COUNT  = 1 << ENT_W;
  localparam int ID_SLOTS   = 1 << ID_W;
  localparam int POOL_SIZE  = (ID_COUNT > ID_SLOTS) ? ID_SLOTS : ID_COUNT;
  localparam int FRESH_W    = ID_W + 1;
  localparam int COUNT_W    = ID_W + 1;

  typedef enum logic [1:0] {
    REQ_ADD        = 2'd0,
    REQ_REMOVE     = 2'd1,
    REQ_GET_ID     = 2'd2,
    REQ_GET_ENTITY = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LINKED = 2'd1,
    ST_ALREADY    = 2'd2,
    ST_NO_FREE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ENT_W-1:0] entity_in;
    logic [ID_W-1:0]  net_id_in;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  net_id_out;
    logic [ENT_W-1:0] entity_out;
  } rsp_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: hdl/idab_ctrl.sv
// ----------------------------------------------------------------------------
// ID allocator controller
// Two-state sequencer: capture a request and launch the table reads, then
// execute once the result register can take a new beat.
// ----------------------------------------------------------------------------
module idab_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  idab_pkg::dp_status_t   dp_status,
  output idab_pkg::ctrl_cmd_t    cmd
);
  import idab_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!dp_status.out_busy) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/idab_datapath.sv
// ----------------------------------------------------------------------------
// ID allocator datapath
// Link tables, valid maps, free ID pool and the result register.
// ----------------------------------------------------------------------------
module idab_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  idab_pkg::req_t       req,
  input  idab_pkg::ctrl_cmd_t  cmd,
  output idab_pkg::dp_status_t dp_status,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output idab_pkg::rsp_t       rsp
);
  import idab_pkg::*;

  req_t                req_q;

  logic [ID_W-1:0]     ent_id_mem [ENT_COUNT];
  logic [ENT_W-1:0]    id_ent_mem [ID_SLOTS];
  logic [ID_W-1:0]     queue_mem  [ID_SLOTS];

  logic [ID_W-1:0]     ent_id_rd;
  logic [ENT_W-1:0]    id_ent_rd;
  logic [ID_W-1:0]     queue_rd;

  logic [ENT_COUNT-1:0] ent_valid_bits;
  logic [ID_SLOTS-1:0]  id_valid_bits;

  logic [FRESH_W-1:0]  fresh_next;
  logic [ID_W-1:0]     recycle_head;
  logic [ID_W-1:0]     recycle_tail;
  logic [COUNT_W-1:0]  recycle_count;

  logic                ent_valid;
  logic                id_valid;
  logic                fresh_avail;
  logic                recycle_avail;
  logic [ID_W-1:0]     alloc_id;
  logic                do_link;
  logic                do_unlink;
  rsp_t                result;

  assign dp_status.out_busy = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= req;
      ent_id_rd <= ent_id_mem[req.entity_in];
      id_ent_rd <= id_ent_mem[req.net_id_in];
      queue_rd  <= queue_mem[recycle_head];
    end
  end

  always_ff @(posedge clk) begin
    if (do_link) begin
      ent_id_mem[req_q.entity_in] <= alloc_id;
      id_ent_mem[alloc_id]        <= req_q.entity_in;
    end
    if (do_unlink) begin
      queue_mem[recycle_tail] <= ent_id_rd;
    end
  end

  always_comb begin
    ent_valid     = ent_valid_bits[req_q.entity_in];
    id_valid      = id_valid_bits[req_q.net_id_in];
    fresh_avail   = fresh_next < FRESH_W'(POOL_SIZE);
    recycle_avail = recycle_count != '0;
    alloc_id      = fresh_avail ? fresh_next[ID_W-1:0] : queue_rd;
    do_link       = 1'b0;
    do_unlink     = 1'b0;
    result.status     = ST_OK;
    result.net_id_out = '0;
    result.entity_out = req_q.entity_in;
    case (req_q.req_type)
      REQ_ADD: begin
        if (ent_valid) begin
          result.status = ST_ALREADY;
        end else if (fresh_avail || recycle_avail) begin
          do_link           = cmd.execute;
          result.net_id_out = alloc_id;
        end else begin
          result.status = ST_NO_FREE;
        end
      end
      REQ_REMOVE: begin
        if (ent_valid) begin
          do_unlink         = cmd.execute;
          result.net_id_out = ent_id_rd;
        end else begin
          result.status = ST_NOT_LINKED;
        end
      end
      REQ_GET_ID: begin
        if (ent_valid) begin
          result.net_id_out = ent_id_rd;
        end else begin
          result.status = ST_NOT_LINKED;
        end
      end
      REQ_GET_ENTITY: begin
        if (id_valid) begin
          result.net_id_out = req_q.net_id_in;
          result.entity_out = id_ent_rd;
        end else begin
          result.status     = ST_NOT_LINKED;
          result.entity_out = '0;
        end
      end
      default: begin
        result.status = ST_NOT_LINKED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid_bits <= '0;
      id_valid_bits  <= '0;
      fresh_next     <= '0;
      recycle_head   <= '0;
      recycle_tail   <= '0;
      recycle_count  <= '0;
    end else begin
      if (do_link) begin
        ent_valid_bits[req_q.entity_in] <= 1'b1;
        id_valid_bits[alloc_id]         <= 1'b1;
        if (fresh_avail) begin
          fresh_next <= fresh_next + FRESH_W'(1);
        end else begin
          recycle_head  <= recycle_head + ID_W'(1);
          recycle_count <= recycle_count - COUNT_W'(1);
        end
      end
      if (do_unlink) begin
        ent_valid_bits[req_q.entity_in] <= 1'b0;
        id_valid_bits[ent_id_rd]        <= 1'b0;
        recycle_tail  <= recycle_tail + ID_W'(1);
        recycle_count <= recycle_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.execute) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp <= result;
    end
  end

endmodule

// File: hdl/id_allocator_bidir_map_unit.sv
// Flow: a request is captured in the idle state and its result beat is registered in
// the execute state, which holds while the previous result beat still waits for ready.
// Requests: one is taken only in the idle state, so no new request is taken before
// the last one executes; the registered table read precedes the write-back in execute.
// Reset: synchronous; valid maps, pool pointers and the result valid flag clear
// with no memory clearing pass.
// ----------------------------------------------------------------------------
// ID allocator bidirectional map unit
// Links entities to allocated network IDs and answers lookups both ways.
// ----------------------------------------------------------------------------
module id_allocator_bidir_map_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  idab_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output idab_pkg::rsp_t  rsp
);
  import idab_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  idab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  idab_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .dp_status (dp_status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: test/idab_link_checker.sv
// ----------------------------------------------------------------------------
// Entity/ID link table checker
// Watches the request and result channels of the link table, predicts each
// result from its own copy of the maps and the ID pool, and compares every
// result beat field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module idab_link_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  idab_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  idab_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import idab_pkg::*;

  logic [FRESH_W-1:0] fresh_next;
  logic [ID_W-1:0]    released_ids[$];
  logic               ent_linked[ENT_COUNT];
  logic [ID_W-1:0]    ent_to_id[ENT_COUNT];
  logic               id_linked[ID_SLOTS];
  logic [ENT_W-1:0]   id_to_ent[ID_SLOTS];
  rsp_t               awaited_answers[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function automatic rsp_t link_table_apply(input req_t r);
    rsp_t             a;
    logic [ID_W-1:0]  id;
    logic [ENT_W-1:0] e;
    logic             got;
    e = r.entity_in;
    id = '0;
    got = 1'b0;
    a.status = ST_OK;
    a.net_id_out = '0;
    a.entity_out = e;
    case (req_kind_t'(r.req_type))
      REQ_ADD: begin
        if (ent_linked[e]) begin
          a.status = ST_ALREADY;
        end else if (fresh_next < POOL_SIZE) begin
          id = fresh_next[ID_W-1:0];
          fresh_next = fresh_next + 1'b1;
          got = 1'b1;
        end else if (released_ids.size() > 0) begin
          id = released_ids.pop_front();
          got = 1'b1;
        end else begin
          a.status = ST_NO_FREE;
        end
        if (got) begin
          ent_linked[e] = 1'b1;
          ent_to_id[e] = id;
          id_linked[id] = 1'b1;
          id_to_ent[id] = e;
          a.net_id_out = id;
        end
      end
      REQ_REMOVE: begin
        if (!ent_linked[e]) begin
          a.status = ST_NOT_LINKED;
        end else begin
          id = ent_to_id[e];
          ent_linked[e] = 1'b0;
          id_linked[id] = 1'b0;
          released_ids.push_back(id);
          a.net_id_out = id;
        end
      end
      REQ_GET_ID: begin
        if (ent_linked[e]) begin
          a.net_id_out = ent_to_id[e];
        end else begin
          a.status = ST_NOT_LINKED;
        end
      end
      default: begin
        if (id_linked[r.net_id_in]) begin
          a.entity_out = id_to_ent[r.net_id_in];
          a.net_id_out = r.net_id_in;
        end else begin
          a.status = ST_NOT_LINKED;
          a.entity_out = '0;
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fresh_next = '0;
      released_ids.delete();
      awaited_answers.delete();
      foreach (ent_linked[i]) ent_linked[i] = 1'b0;
      foreach (id_linked[i]) id_linked[i] = 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected: status %0d id %0d entity %0d",
                                    rsp.status, rsp.net_id_out, rsp.entity_out));
        end else begin
          want = awaited_answers.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status mismatch: got %0d expected %0d",
                                      rsp.status, want.status));
          if (rsp.net_id_out !== want.net_id_out)
            report_mismatch($sformatf("net_id_out mismatch: got %0d expected %0d",
                                      rsp.net_id_out, want.net_id_out));
          if (rsp.entity_out !== want.entity_out)
            report_mismatch($sformatf("entity_out mismatch: got %0d expected %0d",
                                      rsp.entity_out, want.entity_out));
        end
      end
      if (req_valid && req_ready) begin
        awaited_answers.push_back(link_table_apply(req));
      end
    end
    pending <= awaited_answers.size();
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Entity/ID link table testbench
// Drives directed and random add, remove and lookup requests into the link
// table with random idling on both channels; the checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idab_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  int   calm_left = 0;
  int   ready_hold = 0;

  always #1 clk = ~clk;

  id_allocator_bidir_map_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  idab_link_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (rsp_ready) begin
      rsp_ready <= 1'b0;
      ready_hold <= idle_len();
    end else begin
      rsp_ready <= 1'b1;
      ready_hold <= ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6)
                                                 : $urandom_range(20, 80);
    end
  end

  task automatic send_req(input req_kind_t kind, input int ent, input int nid);
    int   gap;
    req_t r;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.req_type = kind;
    r.entity_in = ent[ENT_W-1:0];
    r.net_id_in = nid[ID_W-1:0];
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic req_kind_t pick_kind(input int add_w, input int rem_w, input int get_w);
    int p;
    p = $urandom_range(0, 99);
    if (p < add_w) return REQ_ADD;
    if (p < add_w + rem_w) return REQ_REMOVE;
    if (p < add_w + rem_w + get_w) return REQ_GET_ID;
    return REQ_GET_ENTITY;
  endfunction

  function automatic int narrow_or_full(input int pct_narrow);
    if ($urandom_range(0, 99) < pct_narrow) return $urandom_range(0, 15);
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int base;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_req(REQ_GET_ENTITY, 8'h00, 8'h00);
    send_req(REQ_GET_ENTITY, 8'hFF, 8'hFF);
    send_req(REQ_GET_ID, 8'hFF, 8'h00);
    send_req(REQ_REMOVE, 8'h00, 8'hFF);
    send_req(REQ_ADD, 8'h00, 8'h00);
    send_req(REQ_ADD, 8'hFF, 8'hFF);
    send_req(REQ_ADD, 8'h00, 8'h55);
    send_req(REQ_GET_ID, 8'h00, 8'h00);
    send_req(REQ_GET_ID, 8'hFF, 8'h00);
    send_req(REQ_GET_ENTITY, 8'h00, 8'h01);
    send_req(REQ_GET_ENTITY, 8'hAA, 8'hFF);
    send_req(REQ_REMOVE, 8'h00, 8'h00);
    send_req(REQ_REMOVE, 8'h00, 8'h00);
    send_req(REQ_GET_ENTITY, 8'h33, 8'h00);
    send_req(REQ_ADD, 8'hA5, 8'h5A);
    send_req(REQ_REMOVE, 8'hFF, 8'h00);
    send_req(REQ_ADD, 8'h00, 8'hAA);
    send_req(REQ_GET_ID, 8'h5A, 8'hA5);
    send_req(REQ_GET_ENTITY, 8'h00, 8'h02);

    for (int i = 0; i < 300; i++) begin
      send_req(pick_kind(35, 25, 20), narrow_or_full(75), narrow_or_full(70));
    end
    drain();

    // Linking every entity uses up the never-used IDs, so later adds recycle.
    base = $urandom_range(0, 255);
    for (int i = 0; i < ENT_COUNT; i++) begin
      send_req(REQ_ADD, (base + i) % ENT_COUNT, $urandom_range(0, 255));
    end
    drain();

    for (int i = 0; i < 380; i++) begin
      send_req(pick_kind(30, 30, 20), narrow_or_full(30), narrow_or_full(30));
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
